// ===== src/kwl_pkg.sv =====
// Shared types, token codes and keyword tables for the keyword token lexer.
package kwl_pkg;

  // Token kinds as they appear on the result word.
  typedef enum logic [3:0] {
    TK_END    = 4'd0,
    TK_IDENT  = 4'd1,
    TK_CONST  = 4'd2,
    TK_LOG    = 4'd3,
    TK_INPUT  = 4'd4,
    TK_NUMBER = 4'd5,
    TK_EQUAL  = 4'd6,
    TK_SEMI   = 4'd7,
    TK_DOT    = 4'd8,
    TK_LPAREN = 4'd9,
    TK_RPAREN = 4'd10,
    TK_COMMA  = 4'd11,
    TK_ERROR  = 4'd12
  } tok_kind_e;

  // Character classes produced by the front end.
  typedef enum logic [2:0] {
    CL_SPACE,
    CL_NEWLINE,
    CL_LETTER,
    CL_DIGIT,
    CL_UNDER,
    CL_PUNCT,
    CL_END
  } cls_e;

  // One classified character as it sits in the queue between front and back.
  typedef struct packed {
    cls_e      cls;
    logic [7:0] chr;
    tok_kind_e kind;
  } ent_t;

  // Punctuator and special character codes.
  localparam logic [7:0] CH_EQUAL  = 8'h3d;
  localparam logic [7:0] CH_SEMI   = 8'h3b;
  localparam logic [7:0] CH_DOT    = 8'h2e;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_COMMA  = 8'h2c;
  localparam logic [7:0] CH_UNDER  = 8'h5f;
  localparam logic [7:0] CH_NL     = 8'h0a;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0d;

  // Keyword spellings: const, log, input.
  localparam int unsigned KwCount = 3;
  localparam logic [7:0] KW_TEXT [KwCount][5] = '{
    '{8'h63, 8'h6f, 8'h6e, 8'h73, 8'h74},
    '{8'h6c, 8'h6f, 8'h67, 8'h00, 8'h00},
    '{8'h69, 8'h6e, 8'h70, 8'h75, 8'h74}
  };
  localparam logic [2:0] KW_LEN [KwCount] = '{3'd5, 3'd3, 3'd5};

  // True when keyword k has character c at position idx.
  function automatic logic kw_hit(input logic [1:0] k, input logic [15:0] idx,
                                  input logic [7:0] c);
    logic hit;
    hit = 1'b0;
    if (idx < 16'(KW_LEN[k])) begin
      hit = (KW_TEXT[k][idx[2:0]] == c);
    end
    return hit;
  endfunction

endpackage

// ===== src/kwl_if.sv =====
// Valid/ready channel interfaces for source characters and result tokens.
interface kwl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_input;

  modport source (output valid, output char_code, output end_of_input, input ready);
  modport sink   (input valid, input char_code, input end_of_input, output ready);
endinterface

interface kwl_out_if #(
  parameter int COORD_BITS  = 16,
  parameter int VALUE_BITS  = 32,
  parameter int LENGTH_BITS = 8
);
  logic                   valid;
  logic                   ready;
  logic [3:0]             token_kind;
  logic [COORD_BITS-1:0]  start_line;
  logic [COORD_BITS-1:0]  start_column;
  logic [LENGTH_BITS-1:0] text_length;
  logic [VALUE_BITS-1:0]  number_value;
  logic                   number_overflow;
  logic [7:0]             bad_char;
  logic                   last;

  modport source (output valid, output token_kind, output start_line, output start_column,
                  output text_length, output number_value, output number_overflow,
                  output bad_char, output last, input ready);
  modport sink   (input valid, input token_kind, input start_line, input start_column,
                  input text_length, input number_value, input number_overflow,
                  input bad_char, input last, output ready);
endinterface

// ===== src/keyword_token_lexer.sv =====
// Path: a word is queued in the front queue, then its tokens in the result buffer.
// Throughput: one character per cycle while the result buffer has room; a character
// that closes a pending token and also forms one of its own yields two result words,
// limited by the one output port. Reset: line and column return to 1, lexer goes idle, both queues empty.
// An end-of-input word returns the lexer to the same state after its tokens.
module keyword_token_lexer import kwl_pkg::*; #(
  parameter int COORD_BITS  = 16,
  parameter int VALUE_BITS  = 32,
  parameter int LENGTH_BITS = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  kwl_in_if.sink    in_i,
  kwl_out_if.source out_o
);

  logic fe_valid;
  logic fe_pop;
  ent_t fe_entry;

  // Front end: classification and character queue.
  kwl_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .fe_valid_o (fe_valid),
    .fe_entry_o (fe_entry),
    .fe_pop_i   (fe_pop)
  );

  // Back end: token assembly and result buffer.
  kwl_back #(
    .COORD_BITS  (COORD_BITS),
    .VALUE_BITS  (VALUE_BITS),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fe_valid_i (fe_valid),
    .fe_entry_i (fe_entry),
    .fe_pop_o   (fe_pop),
    .out_o      (out_o)
  );

`ifndef ASSERT_OFF
  // The back end only takes characters from a non-empty queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) fe_pop |-> fe_valid)
    else $error("back end popped an empty character queue");

  // A full front queue is never empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !in_i.ready |-> fe_valid)
    else $error("input stalled with no character queued");

  // End markers and punctuators always leave a word in the result buffer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fe_pop && (fe_entry.cls == CL_END || fe_entry.cls == CL_PUNCT) |=> out_o.valid)
    else $error("token-producing character left no result word");
`endif

endmodule

// ===== src/kwl_front.sv =====
// Front end: accepts source words, classifies each character and queues it.
module kwl_front import kwl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  kwl_in_if.sink      in_i,
  output logic        fe_valid_o,
  output ent_t        fe_entry_o,
  input  logic        fe_pop_i
);

  localparam int Depth = 2;

  ent_t       cls_ent;
  ent_t       q_mem [Depth];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push, full;

  // Character classification.
  always_comb begin
    logic [7:0] c;
    c = in_i.char_code;
    cls_ent.chr  = c;
    cls_ent.kind = TK_ERROR;
    if (in_i.end_of_input) begin
      cls_ent.cls = CL_END;
    end else if (c == CH_NL) begin
      cls_ent.cls = CL_NEWLINE;
    end else if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
      cls_ent.cls = CL_SPACE;
    end else if ((c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a)) begin
      cls_ent.cls = CL_LETTER;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      cls_ent.cls = CL_DIGIT;
    end else if (c == CH_UNDER) begin
      cls_ent.cls = CL_UNDER;
    end else begin
      cls_ent.cls = CL_PUNCT;
      unique case (c)
        CH_EQUAL:  cls_ent.kind = TK_EQUAL;
        CH_SEMI:   cls_ent.kind = TK_SEMI;
        CH_DOT:    cls_ent.kind = TK_DOT;
        CH_LPAREN: cls_ent.kind = TK_LPAREN;
        CH_RPAREN: cls_ent.kind = TK_RPAREN;
        CH_COMMA:  cls_ent.kind = TK_COMMA;
        default:   cls_ent.kind = TK_ERROR;
      endcase
    end
  end

  // Queue handshake: ready depends on occupancy only.
  assign full       = (cnt_q == 2'(Depth));
  assign in_i.ready = !full;
  assign push       = in_i.valid && !full;
  assign fe_valid_o = (cnt_q != 2'd0);
  assign fe_entry_o = q_mem[rp_q];

  // Queue pointers and occupancy.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) begin
        wp_q <= !wp_q;
      end
      if (fe_pop_i) begin
        rp_q <= !rp_q;
      end
      cnt_q <= cnt_q + 2'(push) - 2'(fe_pop_i);
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wp_q] <= cls_ent;
    end
  end

endmodule

// ===== src/kwl_back.sv =====
// Back end: lexer state, token assembly and the result buffer.
module kwl_back import kwl_pkg::*; #(
  parameter int COORD_BITS  = 16,
  parameter int VALUE_BITS  = 32,
  parameter int LENGTH_BITS = 8
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     fe_valid_i,
  input  ent_t     fe_entry_i,
  output logic     fe_pop_o,
  kwl_out_if.source out_o
);

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_IDENT,
    MODE_NUM
  } mode_e;

  typedef struct packed {
    tok_kind_e              kind;
    logic [COORD_BITS-1:0]  line;
    logic [COORD_BITS-1:0]  col;
    logic [LENGTH_BITS-1:0] len;
    logic [VALUE_BITS-1:0]  val;
    logic                   ovf;
    logic [7:0]             bad;
    logic                   last;
  } res_t;

  localparam logic [COORD_BITS-1:0]  CoordMax  = '1;
  localparam logic [LENGTH_BITS-1:0] LengthMax = '1;
  localparam logic [VALUE_BITS-1:0]  ValueMax  = '1;
  localparam int BufDepth = 4;

  mode_e                  mode_q, mode_d;
  logic [COORD_BITS-1:0]  line_q, line_d, col_q, col_d, tstart_q, tstart_d;
  logic [LENGTH_BITS-1:0] tlen_q, tlen_d;
  logic [VALUE_BITS-1:0]  acc_q, acc_d;
  logic                   ovf_q, ovf_d;
  logic [2:0]             kwm_q, kwm_d;

  res_t       obuf [BufDepth];
  logic [1:0] owp_q, orp_q;
  logic [2:0] ocnt_q;
  res_t       r0, r1, pend, newt;
  logic [1:0] nres;
  logic       out_pop;

  // Accept a character only when the buffer can take two words.
  assign fe_pop_o = fe_valid_i && (ocnt_q <= 3'd2);
  assign out_pop  = out_o.valid && out_o.ready;

  // Token assembly and next lexer state.
  always_comb begin
    logic                   is_end, ext_id, ext_num, start, go, id_go, num_go;
    logic                   emit_pend, has_new;
    logic [LENGTH_BITS-1:0] base_len;
    logic [VALUE_BITS-1:0]  base_acc;
    logic                   base_ovf;
    logic [2:0]             base_kwm;
    logic [VALUE_BITS+3:0]  prod;
    logic [COORD_BITS-1:0]  col_inc;
    cls_e                   cls;

    cls     = fe_entry_i.cls;
    is_end  = (cls == CL_END);
    ext_id  = (mode_q == MODE_IDENT) &&
              (cls == CL_LETTER || cls == CL_DIGIT || cls == CL_UNDER);
    ext_num = (mode_q == MODE_NUM) && (cls == CL_DIGIT);
    start   = !is_end && !ext_id && !ext_num && (cls == CL_LETTER || cls == CL_DIGIT);
    go      = ext_id || ext_num || start;
    id_go   = ext_id || (start && cls == CL_LETTER);
    num_go  = ext_num || (start && cls == CL_DIGIT);
    emit_pend = (mode_q != MODE_IDLE) && !ext_id && !ext_num;
    has_new   = is_end || (!go && (cls == CL_UNDER || cls == CL_PUNCT));

    base_len = start ? '0 : tlen_q;
    base_acc = start ? '0 : acc_q;
    base_ovf = start ? 1'b0 : ovf_q;
    base_kwm = start ? 3'b111 : kwm_q;
    col_inc  = (col_q == CoordMax) ? col_q : col_q + 1'b1;

    // Multiply by ten and add the digit, one extra nibble to catch overflow.
    prod = ({4'b0, base_acc} << 3) + ({4'b0, base_acc} << 1) +
           (VALUE_BITS + 4)'(fe_entry_i.chr[3:0]);

    // Pending identifier or number, closed by this character.
    pend      = '0;
    pend.line = line_q;
    pend.col  = tstart_q;
    pend.len  = tlen_q;
    if (mode_q == MODE_NUM) begin
      pend.kind = TK_NUMBER;
      pend.val  = acc_q;
      pend.ovf  = ovf_q;
    end else if (kwm_q[0] && tlen_q == LENGTH_BITS'(KW_LEN[0])) begin
      pend.kind = TK_CONST;
    end else if (kwm_q[1] && tlen_q == LENGTH_BITS'(KW_LEN[1])) begin
      pend.kind = TK_LOG;
    end else if (kwm_q[2] && tlen_q == LENGTH_BITS'(KW_LEN[2])) begin
      pend.kind = TK_INPUT;
    end else begin
      pend.kind = TK_IDENT;
    end

    // Single-character token, end token or error token.
    newt      = '0;
    newt.line = line_q;
    newt.col  = col_q;
    newt.kind = is_end ? TK_END : fe_entry_i.kind;
    newt.bad  = (!is_end && fe_entry_i.kind == TK_ERROR) ? fe_entry_i.chr : 8'h00;
    newt.last = 1'b1;

    r0      = emit_pend ? pend : newt;
    r0.last = !(emit_pend && has_new);
    r1      = newt;
    nres    = 2'(emit_pend) + 2'(has_new);

    // Lexer state update.
    mode_d   = mode_q;
    line_d   = line_q;
    col_d    = col_q;
    tstart_d = tstart_q;
    tlen_d   = tlen_q;
    acc_d    = acc_q;
    ovf_d    = ovf_q;
    kwm_d    = kwm_q;
    if (is_end) begin
      mode_d   = MODE_IDLE;
      line_d   = COORD_BITS'(1);
      col_d    = COORD_BITS'(1);
      tstart_d = COORD_BITS'(1);
      tlen_d   = '0;
      acc_d    = '0;
      ovf_d    = 1'b0;
      kwm_d    = 3'b111;
    end else if (go) begin
      col_d  = col_inc;
      tlen_d = (base_len == LengthMax) ? base_len : base_len + 1'b1;
      acc_d  = base_acc;
      ovf_d  = base_ovf;
      kwm_d  = base_kwm;
      if (start) begin
        mode_d   = (cls == CL_LETTER) ? MODE_IDENT : MODE_NUM;
        tstart_d = col_q;
      end
      if (id_go) begin
        for (int k = 0; k < KwCount; k++) begin
          kwm_d[k] = base_kwm[k] & kw_hit(2'(k), 16'(base_len), fe_entry_i.chr);
        end
      end
      if (num_go) begin
        if (prod[VALUE_BITS+3:VALUE_BITS] != 4'h0) begin
          acc_d = ValueMax;
          ovf_d = 1'b1;
        end else begin
          acc_d = prod[VALUE_BITS-1:0];
        end
      end
    end else begin
      mode_d = MODE_IDLE;
      if (cls == CL_NEWLINE) begin
        line_d = (line_q == CoordMax) ? line_q : line_q + 1'b1;
        col_d  = COORD_BITS'(1);
      end else begin
        col_d = col_inc;
      end
    end
  end

  // Lexer state and buffer control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_IDLE;
      line_q   <= COORD_BITS'(1);
      col_q    <= COORD_BITS'(1);
      tstart_q <= COORD_BITS'(1);
      tlen_q   <= '0;
      acc_q    <= '0;
      ovf_q    <= 1'b0;
      kwm_q    <= 3'b111;
      owp_q    <= 2'd0;
      orp_q    <= 2'd0;
      ocnt_q   <= 3'd0;
    end else begin
      if (fe_pop_o) begin
        mode_q   <= mode_d;
        line_q   <= line_d;
        col_q    <= col_d;
        tstart_q <= tstart_d;
        tlen_q   <= tlen_d;
        acc_q    <= acc_d;
        ovf_q    <= ovf_d;
        kwm_q    <= kwm_d;
        owp_q    <= owp_q + nres;
      end
      if (out_pop) begin
        orp_q <= orp_q + 2'd1;
      end
      ocnt_q <= ocnt_q + (fe_pop_o ? 3'(nres) : 3'd0) - 3'(out_pop);
    end
  end

  // Result buffer storage: up to two words per character.
  always_ff @(posedge clk_i) begin
    if (fe_pop_o && nres != 2'd0) begin
      obuf[owp_q] <= r0;
    end
    if (fe_pop_o && nres == 2'd2) begin
      obuf[owp_q + 2'd1] <= r1;
    end
  end

  // Output word from the buffer head.
  assign out_o.valid           = (ocnt_q != 3'd0);
  assign out_o.token_kind      = obuf[orp_q].kind;
  assign out_o.start_line      = obuf[orp_q].line;
  assign out_o.start_column    = obuf[orp_q].col;
  assign out_o.text_length     = obuf[orp_q].len;
  assign out_o.number_value    = obuf[orp_q].val;
  assign out_o.number_overflow = obuf[orp_q].ovf;
  assign out_o.bad_char        = obuf[orp_q].bad;
  assign out_o.last            = obuf[orp_q].last;

endmodule

// ===== bench/keyword_token_lexer_tb.sv =====
// Self-checking testbench for the keyword token lexer: directed rows, long runs and random text.
module keyword_token_lexer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import kwl_pkg::*;

  localparam int CoordW   = 16;
  localparam int ValueW   = 32;
  localparam int LengthW  = 8;
  localparam int ClkHalf  = 6;
  localparam int ResetCycles = 4;
  localparam int CycleLimit  = 1_000_000;
  localparam int DrainCycles = 20;
  localparam int MaxReports  = 10;
  localparam int PhaseItems  = 160;
  localparam int LongToken   = 260;
  localparam int NumberRun   = 14;

  localparam logic [CoordW-1:0]  CoordMax  = '1;
  localparam logic [ValueW-1:0]  ValueMax  = '1;
  localparam logic [LengthW-1:0] LengthMax = '1;

  // One token word as it leaves the block.
  typedef struct packed {
    tok_kind_e          kind;
    logic [CoordW-1:0]  line;
    logic [CoordW-1:0]  col;
    logic [LengthW-1:0] len;
    logic [ValueW-1:0]  value;
    logic               ovf;
    logic [7:0]         bad;
    logic               last;
  } tok_t;

  typedef enum logic [1:0] {
    SCAN_IDLE,
    SCAN_IDENT,
    SCAN_NUMBER
  } scan_e;

  // One row of the directed table; typed rows carry their single token by hand.
  typedef struct {
    logic [7:0] chr;
    logic       eoi;
    logic       typed;
    tok_t       tok;
  } src_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  kwl_in_if src_if ();
  kwl_out_if #(.COORD_BITS(CoordW), .VALUE_BITS(ValueW), .LENGTH_BITS(LengthW)) tok_if ();

  keyword_token_lexer #(
    .COORD_BITS (CoordW),
    .VALUE_BITS (ValueW),
    .LENGTH_BITS(LengthW)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (src_if),
    .out_o (tok_if)
  );

  always #(ClkHalf) clk = ~clk;

  // Lexer state mirrored by the predictor.
  scan_e               scan;
  logic [CoordW-1:0]   cur_line;
  logic [CoordW-1:0]   cur_col;
  logic [CoordW-1:0]   tok_col;
  logic [LengthW-1:0]  tok_len;
  logic [ValueW-1:0]   acc;
  logic                acc_ovf;
  logic [2:0]          kw_live;
  string               kw_word [3] = '{"const", "log", "input"};

  tok_t     step_toks [$];
  tok_t     tok_q [$];
  src_row_t dir_rows [$];

  int send_idle_pct = 0;
  int stall_pct = 0;
  int sent_cnt = 0;
  int fail_cnt = 0;
  int cycle_cnt = 0;

  function automatic bit is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_num(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function void lex_restart();
    scan     = SCAN_IDLE;
    cur_line = 1;
    cur_col  = 1;
    tok_col  = 1;
    tok_len  = '0;
    acc      = '0;
    acc_ovf  = 1'b0;
    kw_live  = 3'b111;
  endfunction

  function void add_tok(tok_kind_e k, logic [CoordW-1:0] col, logic [LengthW-1:0] len,
                        logic [ValueW-1:0] val, logic ovf, logic [7:0] bad);
    tok_t t;
    t.kind  = k;
    t.line  = cur_line;
    t.col   = col;
    t.len   = len;
    t.value = val;
    t.ovf   = ovf;
    t.bad   = bad;
    t.last  = 1'b0;
    step_toks.push_back(t);
  endfunction

  function void bump_col();
    if (cur_col != CoordMax) cur_col++;
  endfunction

  // Emit the identifier or number in progress, classing keywords by surviving matches.
  function void flush_word();
    tok_kind_e k;
    k = TK_IDENT;
    if (scan == SCAN_IDENT) begin
      for (int i = 0; i < 3; i++) begin
        if (kw_live[i] && k == TK_IDENT && tok_len == kw_word[i].len()) begin
          k = tok_kind_e'(TK_CONST + i);
        end
      end
      add_tok(k, tok_col, tok_len, '0, 1'b0, 8'h00);
    end else if (scan == SCAN_NUMBER) begin
      add_tok(TK_NUMBER, tok_col, tok_len, acc, acc_ovf, 8'h00);
    end
    scan = SCAN_IDLE;
  endfunction

  function void take_letter(logic [7:0] c);
    for (int i = 0; i < 3; i++) begin
      if (tok_len >= kw_word[i].len()) begin
        kw_live[i] = 1'b0;
      end else if (8'(kw_word[i][tok_len]) != c) begin
        kw_live[i] = 1'b0;
      end
    end
    if (tok_len != LengthMax) tok_len++;
  endfunction

  // Decimal accumulation that sticks at the maximum once it would overflow.
  function void take_digit(logic [7:0] c);
    logic [63:0] d;
    d = 64'(c) - 64'("0");
    if (64'(acc) <= (64'(ValueMax) - d) / 10) begin
      acc = ValueW'(64'(acc) * 10 + d);
    end else begin
      acc     = ValueMax;
      acc_ovf = 1'b1;
    end
    if (tok_len != LengthMax) tok_len++;
  endfunction

  // Work out the tokens that one accepted word causes and advance the mirror state.
  function void lex_char(logic [7:0] c, logic eoi);
    tok_kind_e pk;
    step_toks.delete();
    if (eoi) begin
      flush_word();
      add_tok(TK_END, cur_col, '0, '0, 1'b0, 8'h00);
      lex_restart();
    end else if (scan == SCAN_IDENT && (is_alpha(c) || is_num(c) || c == CH_UNDER)) begin
      take_letter(c);
      bump_col();
    end else if (scan == SCAN_NUMBER && is_num(c)) begin
      take_digit(c);
      bump_col();
    end else begin
      flush_word();
      if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
        if (c == CH_NL) begin
          if (cur_line != CoordMax) cur_line++;
          cur_col = 1;
        end else begin
          bump_col();
        end
      end else if (is_alpha(c) || is_num(c)) begin
        scan    = is_alpha(c) ? SCAN_IDENT : SCAN_NUMBER;
        tok_col = cur_col;
        tok_len = '0;
        acc     = '0;
        acc_ovf = 1'b0;
        kw_live = 3'b111;
        if (scan == SCAN_IDENT) take_letter(c);
        else take_digit(c);
        bump_col();
      end else begin
        case (c)
          CH_EQUAL:  pk = TK_EQUAL;
          CH_SEMI:   pk = TK_SEMI;
          CH_DOT:    pk = TK_DOT;
          CH_LPAREN: pk = TK_LPAREN;
          CH_RPAREN: pk = TK_RPAREN;
          CH_COMMA:  pk = TK_COMMA;
          default:   pk = TK_ERROR;
        endcase
        add_tok(pk, cur_col, '0, '0, 1'b0, (pk == TK_ERROR) ? c : 8'h00);
        bump_col();
      end
    end
    if (step_toks.size() != 0) step_toks[step_toks.size()-1].last = 1'b1;
  endfunction

  function automatic tok_t mk_tok(tok_kind_e k, int line, int col, logic [7:0] bad);
    tok_t t;
    t      = '0;
    t.kind = k;
    t.line = CoordW'(line);
    t.col  = CoordW'(col);
    t.bad  = bad;
    t.last = 1'b1;
    return t;
  endfunction

  function void add_text(string s);
    for (int i = 0; i < s.len(); i++) dir_rows.push_back('{8'(s[i]), 1'b0, 1'b0, '0});
  endfunction

  function automatic string tok_str(tok_t t);
    return $sformatf("kind %0d line %0d col %0d len %0d value %0d ovf %0b bad %02h last %0b",
                     t.kind, t.line, t.col, t.len, t.value, t.ovf, t.bad, t.last);
  endfunction

  function automatic logic [7:0] rand_alpha();
    return $urandom_range(1) ? 8'("a" + $urandom_range(25)) : 8'("A" + $urandom_range(25));
  endfunction

  function automatic logic [7:0] rand_word_char();
    int r;
    r = $urandom_range(9);
    if (r < 6) return rand_alpha();
    if (r < 9) return 8'("0" + $urandom_range(9));
    return CH_UNDER;
  endfunction

  // Offer one word, idling first at random, and record its tokens once accepted.
  task automatic push_char(input logic [7:0] c, input logic eoi,
                           input logic typed = 1'b0, input tok_t fixed = '0);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      src_if.valid <= 1'b0;
      @(negedge clk);
    end
    src_if.valid        <= 1'b1;
    src_if.char_code    <= c;
    src_if.end_of_input <= eoi;
    @(posedge clk);
    while (src_if.ready !== 1'b1) @(posedge clk);
    lex_char(c, eoi);
    if (typed) tok_q.push_back(fixed);
    else foreach (step_toks[i]) tok_q.push_back(step_toks[i]);
    sent_cnt++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) push_char(8'(s[i]), 1'b0);
  endtask

  task automatic hold_until_drained();
    @(negedge clk);
    src_if.valid <= 1'b0;
    while (tok_q.size() != 0) @(posedge clk);
  endtask

  // One random piece of source text: mostly tokens, some whitespace, noise and end markers.
  task automatic send_random_piece();
    int         r;
    int         n;
    string      w;
    logic [7:0] puncts [6] = '{CH_EQUAL, CH_SEMI, CH_DOT, CH_LPAREN, CH_RPAREN, CH_COMMA};
    logic [7:0] blanks [6] = '{CH_SPACE, CH_TAB, CH_NL, 8'h0b, 8'h0c, CH_CR};
    r = $urandom_range(99);
    if (r < 12) begin
      w = kw_word[$urandom_range(2)];
      case ($urandom_range(3))
        0: w = w.substr(0, w.len() - 2);
        1: w = {w, "_"};
        2: w = {w, "s"};
        default: ;
      endcase
      send_text(w);
    end else if (r < 32) begin
      n = $urandom_range(10, 1);
      push_char(rand_alpha(), 1'b0);
      repeat (n - 1) push_char(rand_word_char(), 1'b0);
    end else if (r < 50) begin
      case ($urandom_range(4))
        0: send_text("4294967295");
        1: send_text("4294967296");
        2: send_text("0");
        default: begin
          n = $urandom_range(12, 1);
          repeat (n) push_char(8'("0" + $urandom_range(9)), 1'b0);
        end
      endcase
    end else if (r < 65) begin
      push_char(puncts[$urandom_range(5)], 1'b0);
    end else if (r < 83) begin
      repeat ($urandom_range(3, 1)) push_char(blanks[$urandom_range(5)], 1'b0);
    end else if (r < 93) begin
      push_char(8'($urandom_range(255)), 1'b0);
    end else begin
      push_char(8'($urandom_range(255)), 1'b1);
    end
  endtask

  // Receiver stalls at the rate of the current phase.
  always @(negedge clk) begin
    tok_if.ready <= rst_n && ($urandom_range(99) >= stall_pct);
  end

  // Compare every accepted token word with the oldest expectation.
  always @(posedge clk) begin
    tok_t got;
    tok_t want;
    if (tok_if.valid === 1'b1 && tok_if.ready === 1'b1) begin
      got.kind  = tok_kind_e'(tok_if.token_kind);
      got.line  = tok_if.start_line;
      got.col   = tok_if.start_column;
      got.len   = tok_if.text_length;
      got.value = tok_if.number_value;
      got.ovf   = tok_if.number_overflow;
      got.bad   = tok_if.bad_char;
      got.last  = tok_if.last;
      if (tok_q.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= MaxReports) $display("unexpected token word: %s", tok_str(got));
      end else begin
        want = tok_q.pop_front();
        if (got !== want) begin
          fail_cnt++;
          if (fail_cnt <= MaxReports) begin
            $display("token mismatch: expected %s", tok_str(want));
            $display("                got      %s", tok_str(got));
          end
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int send_tab [4];
    int stall_tab [4];
    int goal;
    bit held;
    send_tab  = '{0, 77, 0, 15};
    stall_tab = '{0, 0, 77, 15};
    held      = 1'b0;
    src_if.valid        = 1'b0;
    src_if.char_code    = 8'h00;
    src_if.end_of_input = 1'b0;
    tok_if.ready        = 1'b0;
    lex_restart();

    // Directed table: punctuators, error bytes, keywords, a number and end markers.
    dir_rows.push_back('{CH_COMMA,  1'b0, 1'b1, mk_tok(TK_COMMA, 1, 1, 8'h00)});
    dir_rows.push_back('{CH_EQUAL,  1'b0, 1'b1, mk_tok(TK_EQUAL, 1, 2, 8'h00)});
    dir_rows.push_back('{CH_SEMI,   1'b0, 1'b1, mk_tok(TK_SEMI, 1, 3, 8'h00)});
    dir_rows.push_back('{CH_DOT,    1'b0, 1'b1, mk_tok(TK_DOT, 1, 4, 8'h00)});
    dir_rows.push_back('{CH_LPAREN, 1'b0, 1'b1, mk_tok(TK_LPAREN, 1, 5, 8'h00)});
    dir_rows.push_back('{CH_RPAREN, 1'b0, 1'b1, mk_tok(TK_RPAREN, 1, 6, 8'h00)});
    dir_rows.push_back('{8'hff,     1'b0, 1'b1, mk_tok(TK_ERROR, 1, 7, 8'hff)});
    dir_rows.push_back('{8'h00,     1'b0, 1'b1, mk_tok(TK_ERROR, 1, 8, 8'h00)});
    dir_rows.push_back('{CH_NL,     1'b0, 1'b0, '0});
    add_text("const;");
    add_text("log(");
    // An underscore cannot extend a number, so it closes it and is an error byte.
    add_text("07_");
    dir_rows.push_back('{8'h5a, 1'b1, 1'b1, mk_tok(TK_END, 2, 14, 8'h00)});
    add_text("input");
    dir_rows.push_back('{8'h00, 1'b1, 1'b0, '0});

    repeat (ResetCycles) @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      push_char(dir_rows[i].chr, dir_rows[i].eoi, dir_rows[i].typed, dir_rows[i].tok);
    end

    // Saturation runs: token length, then number value.
    repeat (LongToken) push_char(rand_alpha(), 1'b0);
    push_char(CH_SPACE, 1'b0);
    repeat (NumberRun) push_char("9", 1'b0);
    push_char(CH_COMMA, 1'b0);
    push_char("x", 1'b0);
    push_char(8'h00, 1'b1);
    hold_until_drained();

    // Random text under each idling pattern.
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = send_tab[p];
      stall_pct     = stall_tab[p];
      goal          = sent_cnt + PhaseItems;
      while (sent_cnt < goal) begin
        send_random_piece();
        if (p == 1 && !held && sent_cnt >= goal - PhaseItems / 2) begin
          hold_until_drained();
          held = 1'b1;
        end
      end
    end

    hold_until_drained();
    repeat (DrainCycles) @(posedge clk);
    if (fail_cnt == 0 && tok_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
